// ----- src/lost_pkg.sv -----
// ---------------------------------------------------------------------------
// LRU open slot tracker package
// Shared widths, command codes, payload types and the control word that is
// broadcast to every cell of the recency list.
// ---------------------------------------------------------------------------
package lost_pkg;

   localparam int unsigned ID_W    = 8;
   localparam int unsigned SLOTS   = 16;
   localparam int unsigned CNT_W   = 5;
   localparam int unsigned LIMIT_W = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(SLOTS);

   typedef enum logic [0:0] {
      CMD_TOUCH  = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type           command;
      logic [ID_W-1:0]   resource_id;
   } req_type;

   typedef struct packed {
      logic              evicted_valid;
      logic [ID_W-1:0]   evicted_id;
      logic [CNT_W-1:0]  open_count;
   } rsp_type;

   typedef struct packed {
      logic              touch;
      logic              remove;
      logic              found;
      logic              evict;
      logic [ID_W-1:0]   id;
   } cell_ctrl_type;

endpackage

// ----- src/lost_cell.sv -----
// ---------------------------------------------------------------------------
// LRU list cell
// One position of the recency list. It compares its id with the broadcast
// id and takes its next value from either neighbor or keeps its own.
// ---------------------------------------------------------------------------
module lost_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  lost_pkg::cell_ctrl_type       ctrl,
   input  logic [lost_pkg::ID_W-1:0]     left_id,
   input  logic                          left_valid,
   input  logic                          left_before,
   input  logic [lost_pkg::ID_W-1:0]     right_id,
   input  logic                          right_valid,
   output logic [lost_pkg::ID_W-1:0]     id,
   output logic                          valid,
   output logic                          before_out,
   output logic [lost_pkg::ID_W-1:0]     tail_id
);
   import lost_pkg::*;

   logic [ID_W-1:0] id_ff;
   logic [ID_W-1:0] id_in;
   logic            valid_ff;
   logic            valid_in;
   logic            match;
   logic            shift;

   assign match      = valid_ff && (id_ff == ctrl.id);
   assign before_out = left_before | match;
   assign id         = id_ff;
   assign valid      = valid_ff;
   assign tail_id    = (valid_ff && !right_valid) ? id_ff : '0;

   always_comb begin
      id_in    = id_ff;
      valid_in = valid_ff;
      shift    = ctrl.found ? !left_before : (ctrl.evict ? valid_ff : left_valid);
      if (ctrl.touch) begin
         if (shift) begin
            id_in = left_id;
         end
         if (!ctrl.found && !ctrl.evict) begin
            valid_in = valid_ff | left_valid;
         end
      end else if (ctrl.remove && ctrl.found) begin
         if ((left_before || match) && right_valid) begin
            id_in = right_id;
         end
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- src/lru_open_slot_tracker_top.sv -----
// ---------------------------------------------------------------------------
// LRU open slot tracker
// Keeps a recency-ordered list of open resource ids as a row of cells,
// moves touched ids to the front and evicts the least recent one when full.
// ---------------------------------------------------------------------------
// Usage:
// A request is a transfer on req_data when start is high and busy is low.
// Command touch moves the id to the most recent place, inserting it and
// evicting the least recent id if it holds max_open (clamped 1..16) or more.
// Command remove unlinks the id if it is listed.
// Every request gives exactly one response on rsp_data, marked by rsp_valid
// for one cycle, in the cycle after the request transfer. busy stays low,
// so a new request may be given in every cycle: one item per cycle, as each
// request is one broadcast compare and shift across the sixteen cells.
// The receiver cannot stall; each response must be taken when shown.
// csr_data sets max_open on a csr_valid transfer; csr_ready is always high.
// Write it only while no request is outstanding.
// Reset empties the list, clears the count and sets max_open to sixteen.
// ---------------------------------------------------------------------------
module lru_open_slot_tracker_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  lost_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output lost_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lost_pkg::LIMIT_W-1:0]   csr_data
);
   import lost_pkg::*;

   logic [LIMIT_W-1:0] max_open_ff;
   logic [CNT_W-1:0]   occ_ff;
   logic [CNT_W-1:0]   occ_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;
   logic [CNT_W-1:0]   limit;
   logic               accept;
   logic               found;
   logic [ID_W-1:0]    evict_id;
   cell_ctrl_type      ctrl;

   logic [ID_W-1:0]    slot_id    [SLOTS+1];
   logic               slot_valid [SLOTS+1];
   logic               hit_seen   [SLOTS+1];
   logic [ID_W-1:0]    tail_id    [SLOTS];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (max_open_ff == '0) begin
         limit = CNT_W'(1);
      end else if (max_open_ff > LIMIT_W'(SLOTS)) begin
         limit = CNT_W'(SLOTS);
      end else begin
         limit = CNT_W'(max_open_ff);
      end
   end

   assign found = hit_seen[SLOTS];

   always_comb begin
      ctrl.touch  = accept && (req_data.command == CMD_TOUCH);
      ctrl.remove = accept && (req_data.command == CMD_REMOVE);
      ctrl.found  = found;
      ctrl.evict  = ctrl.touch && !found && (occ_ff >= limit);
      ctrl.id     = req_data.resource_id;
   end

   assign slot_id[SLOTS]    = '0;
   assign slot_valid[SLOTS] = 1'b0;
   assign hit_seen[0]       = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [ID_W-1:0] left_id;
      logic            left_valid;
      if (i == 0) begin : g_head
         assign left_id    = req_data.resource_id;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_id    = slot_id[i-1];
         assign left_valid = slot_valid[i-1];
      end
      lost_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_id     (left_id),
         .left_valid  (left_valid),
         .left_before (hit_seen[i]),
         .right_id    (slot_id[i+1]),
         .right_valid (slot_valid[i+1]),
         .id          (slot_id[i]),
         .valid       (slot_valid[i]),
         .before_out  (hit_seen[i+1]),
         .tail_id     (tail_id[i])
      );
   end

   always_comb begin
      evict_id = '0;
      for (int i = 0; i < SLOTS; i++) begin
         evict_id = evict_id | tail_id[i];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.touch && !found && !ctrl.evict) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (ctrl.remove && found) begin
         occ_in = occ_ff - CNT_W'(1);
      end
      rsp_data_in.evicted_valid = ctrl.evict;
      rsp_data_in.evicted_id    = ctrl.evict ? evict_id : '0;
      rsp_data_in.open_count    = occ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_open_ff  <= LIMIT_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_open_ff <= csr_data;
         end
         occ_ff       <= occ_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
